// ===== src/esd_pkg.sv =====
package esd_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam int TOTAL_W = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_OCT1 = 2'd2;
   localparam logic [1:0] MODE_OCT2 = 2'd3;

   typedef struct packed {
      logic [7:0] value;
      logic last;
   } entry_type;

   typedef struct packed {
      logic push0;
      logic push1;
      entry_type entry0;
      entry_type entry1;
   } push_type;

   function automatic logic is_octal(input logic [7:0] b);
      is_octal = (b[7:3] == CHAR_ZERO[7:3]);
   endfunction

   // character for an escape letter or a backslash; hit low when none
   function automatic logic [8:0] escape_map(input logic [7:0] b);
      unique case (b)
         8'h6E: escape_map = {1'b1, 8'h0A};
         8'h74: escape_map = {1'b1, 8'h09};
         8'h66: escape_map = {1'b1, 8'h0C};
         8'h72: escape_map = {1'b1, 8'h0D};
         8'h62: escape_map = {1'b1, 8'h08};
         CHAR_BACKSLASH: escape_map = {1'b1, CHAR_BACKSLASH};
         default: escape_map = {1'b0, 8'h00};
      endcase
   endfunction

endpackage

// ===== src/esd_if.sv =====
interface esd_req_if;
   logic valid;
   logic ready;
   logic [7:0] in_byte;
   logic in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_byte;
   logic out_last;
   logic [esd_pkg::TOTAL_W-1:0] out_total;

   modport source (output valid, output out_byte, output out_last, output out_total,
                   input ready);
   modport sink (input valid, input out_byte, input out_last, input out_total,
                 output ready);
endinterface

// ===== src/escape_sequence_decoder.sv =====
// Backslash escape decoder.
// req carries one escaped byte per transaction (in_byte, in_last marks the
// final byte of a string). rsp carries the unescaped bytes (out_byte), a
// flag on the final one (out_last) and the running count of output bytes
// of the string, saturating (out_total).
// The front classifies each byte and pushes zero, one or two entries into
// a four-entry queue; the back stamps the running count and holds the
// result in an output register.
// A request passes through the queue and the output register before it
// reaches rsp. Requests are taken one per cycle while the queue has room;
// results leave one per cycle while the rsp receiver is ready.
// A byte that ends a pending octal value may yield two results, which
// drain one per cycle from the queue while the rsp receiver is ready;
// req_ready falls while fewer than two queue slots are free.
// Reset clears the escape state, the queue, the count and rsp valid.
// When the rsp receiver stalls, the output register holds its result, the
// queue fills and req ready drops.
module escape_sequence_decoder (
   input logic clock,
   input logic reset,
   esd_req_if.sink req,
   esd_rsp_if.source rsp
);

   esd_pkg::push_type push;
   esd_pkg::entry_type q_entry;
   logic space_ok;
   logic q_valid;
   logic q_pop;

   esd_front u_front (
      .clock (clock),
      .reset (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_byte (req.in_byte),
      .in_last (req.in_last),
      .space_ok (space_ok),
      .push (push)
   );

   esd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push (push),
      .space_ok (space_ok),
      .out_valid (q_valid),
      .out_entry (q_entry),
      .pop (q_pop)
   );

   esd_back u_back (
      .clock (clock),
      .reset (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop (q_pop),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_byte (rsp.out_byte),
      .out_last (rsp.out_last),
      .out_total (rsp.out_total)
   );

endmodule

// ===== src/esd_front.sv =====
module esd_front (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input logic [7:0] in_byte,
   input logic in_last,
   input logic space_ok,
   output esd_pkg::push_type push
);

   logic [1:0] mode_ff, mode_in;
   logic [7:0] oct_ff, oct_in;
   logic accept;
   logic [8:0] mapped;
   logic [7:0] oct_next;
   logic [7:0] digit;

   // plain-text handling of a byte, into the given slot
   logic plain_emit;
   logic [1:0] plain_mode;

   assign in_ready = space_ok;
   assign accept = in_valid && space_ok;
   assign mapped = esd_pkg::escape_map(in_byte);
   assign digit = in_byte - esd_pkg::CHAR_ZERO;
   assign oct_next = {oct_ff[4:0], digit[2:0]};

   always_comb begin
      if (in_byte == esd_pkg::CHAR_BACKSLASH && !in_last) begin
         plain_emit = 1'b0;
         plain_mode = esd_pkg::MODE_ESCAPE;
      end else begin
         plain_emit = 1'b1;
         plain_mode = esd_pkg::MODE_PLAIN;
      end
   end

   always_comb begin
      push = '0;
      push.entry0.value = in_byte;
      push.entry0.last = in_last;
      push.entry1.value = in_byte;
      push.entry1.last = in_last;
      mode_in = mode_ff;
      oct_in = oct_ff;
      unique case (mode_ff)
         esd_pkg::MODE_PLAIN: begin
            push.push0 = plain_emit;
            mode_in = plain_mode;
         end
         esd_pkg::MODE_ESCAPE: begin
            if (mapped[8]) begin
               push.push0 = 1'b1;
               push.entry0.value = mapped[7:0];
               mode_in = esd_pkg::MODE_PLAIN;
            end else if (esd_pkg::is_octal(in_byte)) begin
               oct_in = {5'd0, digit[2:0]};
               mode_in = esd_pkg::MODE_OCT1;
               push.push0 = in_last;
               push.entry0.value = {5'd0, digit[2:0]};
            end else begin
               push.push0 = 1'b1;
               mode_in = esd_pkg::MODE_PLAIN;
            end
         end
         esd_pkg::MODE_OCT1: begin
            if (esd_pkg::is_octal(in_byte)) begin
               oct_in = oct_next;
               mode_in = esd_pkg::MODE_OCT2;
               push.push0 = in_last;
               push.entry0.value = oct_next;
            end else begin
               push.push0 = 1'b1;
               push.entry0.value = oct_ff;
               push.entry0.last = 1'b0;
               push.push1 = plain_emit;
               mode_in = plain_mode;
            end
         end
         default: begin
            if (esd_pkg::is_octal(in_byte)) begin
               push.push0 = 1'b1;
               push.entry0.value = oct_next;
               mode_in = esd_pkg::MODE_PLAIN;
            end else begin
               push.push0 = 1'b1;
               push.entry0.value = oct_ff;
               push.entry0.last = 1'b0;
               push.push1 = plain_emit;
               mode_in = plain_mode;
            end
         end
      endcase
      if (in_last) begin
         mode_in = esd_pkg::MODE_PLAIN;
         oct_in = '0;
      end
      if (!accept) begin
         push.push0 = 1'b0;
         push.push1 = 1'b0;
         mode_in = mode_ff;
         oct_in = oct_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= esd_pkg::MODE_PLAIN;
         oct_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         oct_ff <= oct_in;
      end
   end

endmodule

// ===== src/esd_queue.sv =====
module esd_queue (
   input logic clock,
   input logic reset,
   input esd_pkg::push_type push,
   output logic space_ok,
   output logic out_valid,
   output esd_pkg::entry_type out_entry,
   input logic pop
);

   esd_pkg::entry_type slots_ff [esd_pkg::QUEUE_DEPTH];
   logic [esd_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [esd_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [esd_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic [esd_pkg::QPTR_W-1:0] wr_next;
   logic do_pop;

   // two free slots needed: one transaction may push two entries
   assign space_ok = (cnt_ff <= esd_pkg::QCNT_W'(esd_pkg::QUEUE_DEPTH - 2));
   assign out_valid = (cnt_ff != '0);
   assign out_entry = slots_ff[rd_ff];
   assign do_pop = pop && out_valid;
   assign wr_next = wr_ff + 1'b1;

   always_comb begin
      wr_in = wr_ff + esd_pkg::QPTR_W'(push.push0) + esd_pkg::QPTR_W'(push.push1);
      rd_in = rd_ff + esd_pkg::QPTR_W'(do_pop);
      cnt_in = cnt_ff + esd_pkg::QCNT_W'(push.push0) + esd_pkg::QCNT_W'(push.push1)
               - esd_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         slots_ff[wr_ff] <= push.entry0;
      end
      if (push.push1) begin
         slots_ff[wr_next] <= push.entry1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= esd_pkg::QCNT_W'(esd_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0)
      else $error("second entry pushed without first");
   a_push_space: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> space_ok)
      else $error("push without room");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ff == rd_ff))
      else $error("empty queue with pointers apart");
`endif

endmodule

// ===== src/esd_back.sv =====
module esd_back (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input esd_pkg::entry_type q_entry,
   output logic q_pop,
   output logic out_valid,
   input logic out_ready,
   output logic [7:0] out_byte,
   output logic out_last,
   output logic [esd_pkg::TOTAL_W-1:0] out_total
);

   logic valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic last_ff;
   logic [esd_pkg::CNT_W-1:0] total_ff;
   logic [esd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [esd_pkg::CNT_W-1:0] count_next;

   assign q_pop = q_valid && (!valid_ff || out_ready);
   assign count_next = (&count_ff) ? count_ff : count_ff + 1'b1;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         count_in = q_entry.last ? '0 : count_next;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         byte_ff <= q_entry.value;
         last_ff <= q_entry.last;
         total_ff <= count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte = byte_ff;
   assign out_last = last_ff;
   assign out_total = esd_pkg::TOTAL_W'(total_ff);

`ifndef ASSERT_OFF
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (total_ff != '0))
      else $error("result with zero running total");
   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_entry.last) |=> (count_ff == '0))
      else $error("count not cleared after final byte");
`endif

endmodule

// ===== bench/escape_sequence_decoder_tb.sv =====
`timescale 1ns / 1ps

module escape_sequence_decoder_tb;

   localparam int CLK_HALF = 2;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 720;
   localparam int HOLD_AFTER = 250;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int COUNT_MAX = (1 << esd_pkg::CNT_W) - 1;

   localparam logic [7:0] CH_BSL = esd_pkg::CHAR_BACKSLASH;
   localparam logic [7:0] CH_N = "n";
   localparam logic [7:0] CH_T = "t";
   localparam logic [7:0] CH_F = "f";
   localparam logic [7:0] CH_R = "r";
   localparam logic [7:0] CH_B = "b";
   localparam logic [7:0] CH_0 = "0";
   localparam logic [7:0] CH_7 = "7";
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_TAB = 8'h09;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_BS = 8'h08;

   typedef struct packed {
      logic [7:0] code;
      logic last;
   } escaped_type;

   typedef struct packed {
      logic [7:0] value;
      logic last;
      logic [esd_pkg::TOTAL_W-1:0] total;
   } unescaped_type;

   logic clock;
   logic reset;

   esd_req_if req();
   esd_rsp_if rsp();

   escape_sequence_decoder DUT (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   escaped_type escaped_q[$];
   unescaped_type unescaped_q[$];
   logic [7:0] str_buf[$];

   // decoder shadow state
   logic [1:0] esc_mode = esd_pkg::MODE_PLAIN;
   logic [7:0] octal_acc = '0;
   int out_count;

   int fail_count;
   int req_count;
   int rsp_count;
   int stall_cycles;
   logic req_taken;
   logic rsp_taken;
   logic hold_rsp;
   int unsigned req_gap;
   int unsigned rsp_gap;
   logic req_burst = 1'b0;
   logic rsp_burst = 1'b0;
   unescaped_type want;

   function automatic logic [8:0] control_for(input logic [7:0] b);
      case (b)
         CH_N: return {1'b1, CTL_LF};
         CH_T: return {1'b1, CTL_TAB};
         CH_F: return {1'b1, CTL_FF};
         CH_R: return {1'b1, CTL_CR};
         CH_B: return {1'b1, CTL_BS};
         CH_BSL: return {1'b1, CH_BSL};
         default: return 9'd0;
      endcase
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= CH_0 && b <= CH_7;
   endfunction

   function automatic void emit_byte(input logic [7:0] value, input logic last);
      if (out_count < COUNT_MAX) out_count++;
      unescaped_q.push_back('{value, last, esd_pkg::TOTAL_W'(out_count)});
   endfunction

   function automatic void plain_in(input logic [7:0] b, input logic last);
      if (b == CH_BSL && !last) begin
         esc_mode = esd_pkg::MODE_ESCAPE;
      end else begin
         esc_mode = esd_pkg::MODE_PLAIN;
         emit_byte(b, last);
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic last);
      logic [8:0] ctl;
      ctl = control_for(b);
      case (esc_mode)
         esd_pkg::MODE_PLAIN: plain_in(b, last);
         esd_pkg::MODE_ESCAPE: begin
            if (ctl[8]) begin
               esc_mode = esd_pkg::MODE_PLAIN;
               emit_byte(ctl[7:0], last);
            end else if (is_digit(b)) begin
               octal_acc = {5'd0, b[2:0]};
               esc_mode = esd_pkg::MODE_OCT1;
               if (last) emit_byte(octal_acc, 1'b1);
            end else begin
               esc_mode = esd_pkg::MODE_PLAIN;
               emit_byte(b, last);
            end
         end
         default: begin
            if (is_digit(b)) begin
               // value wraps to its low 8 bits
               octal_acc = {octal_acc[4:0], b[2:0]};
               if (esc_mode == esd_pkg::MODE_OCT2) begin
                  esc_mode = esd_pkg::MODE_PLAIN;
                  emit_byte(octal_acc, last);
               end else begin
                  esc_mode = esd_pkg::MODE_OCT2;
                  if (last) emit_byte(octal_acc, 1'b1);
               end
            end else begin
               // pending value goes out first, then the byte is plain text
               emit_byte(octal_acc, 1'b0);
               plain_in(b, last);
            end
         end
      endcase
      if (last) begin
         esc_mode = esd_pkg::MODE_PLAIN;
         octal_acc = '0;
         out_count = 0;
      end
   endfunction

   function automatic logic [7:0] random_digit();
      return CH_0 | 8'($urandom_range(0, 7));
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      if ($urandom_range(0, 49) == 0) return 8'h00;
      if ($urandom_range(0, 9) == 0) return random_digit();
      do b = 8'($urandom_range(1, 255)); while (b == CH_BSL);
      return b;
   endfunction

   function automatic void add_token(input int plain_pct);
      logic [7:0] b;
      if ($urandom_range(0, 99) < plain_pct) begin
         str_buf.push_back(plain_char());
      end else begin
         str_buf.push_back(CH_BSL);
         case ($urandom_range(0, 3))
            0: begin
               case ($urandom_range(0, 5))
                  0: str_buf.push_back(CH_N);
                  1: str_buf.push_back(CH_T);
                  2: str_buf.push_back(CH_F);
                  3: str_buf.push_back(CH_R);
                  4: str_buf.push_back(CH_B);
                  default: str_buf.push_back(CH_BSL);
               endcase
            end
            1: begin
               do b = 8'($urandom_range(0, 255)); while (is_digit(b) || control_for(b) != 0);
               str_buf.push_back(b);
            end
            default: repeat ($urandom_range(1, 3)) str_buf.push_back(random_digit());
         endcase
      end
   endfunction

   function automatic void flush_string();
      foreach (str_buf[i]) escaped_q.push_back('{str_buf[i], i == str_buf.size() - 1});
      str_buf.delete();
   endfunction

   function automatic void report(input string what, input int exp_v, input int act_v);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      fail_count++;
   endfunction

   task automatic wait_drained();
      while (escaped_q.size() != 0 || req.valid || unescaped_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      #4ms;
      $display("Verification failed");
      $finish;
   end

   // prediction and checking
   always @(posedge clock) begin
      req_taken <= !reset && req.valid && req.ready;
      rsp_taken <= !reset && rsp.valid && rsp.ready;
      if (!reset && req.valid && !req.ready) stall_cycles++;
      if (!reset && req.valid && req.ready) begin
         decode_byte(req.in_byte, req.in_last);
         req_count++;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_count++;
         if (unescaped_q.size() == 0) begin
            report("unexpected transaction, out_byte", -1, rsp.out_byte);
         end else begin
            want = unescaped_q.pop_front();
            if (rsp.out_byte !== want.value) report("out_byte", want.value, rsp.out_byte);
            if (rsp.out_last !== want.last) report("out_last", want.last, rsp.out_last);
            if (rsp.out_total !== want.total) report("out_total", want.total, rsp.out_total);
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.in_byte <= 8'h00;
         req.in_last <= 1'b0;
         req_gap = 0;
      end else if (!req.valid || req_taken) begin
         if (req_gap > 0) begin
            req.valid <= 1'b0;
            req_gap--;
         end else if (escaped_q.size() > 0) begin
            req.valid <= 1'b1;
            req.in_byte <= escaped_q[0].code;
            req.in_last <= escaped_q[0].last;
            void'(escaped_q.pop_front());
            if ($urandom_range(0, 29) == 0) req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 13);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 29) == 0) rsp_burst = !rsp_burst;
            rsp_gap = rsp_burst ? 0 : $urandom_range(0, 13);
         end
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // long receiver stall while requests keep coming
   initial begin
      hold_rsp = 1'b0;
      while (req_count < HOLD_AFTER) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      int random_items;
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every control escape
      str_buf = '{CH_BSL, CH_N, CH_BSL, CH_T, CH_BSL, CH_F, CH_BSL, CH_R, CH_BSL, CH_B,
                  CH_BSL, CH_BSL};
      flush_string();
      // octal above 255, octal cut by a backslash, other escape, octal cut by a non-octal digit
      str_buf = '{CH_BSL, CH_7, CH_7, CH_7, CH_BSL, "1", CH_BSL, "q", CH_BSL, "1", "9"};
      flush_string();
      // zero byte plain and escaped, top byte, trailing backslash
      str_buf = '{8'h00, CH_BSL, 8'h00, 8'hFF, CH_BSL};
      flush_string();
      // string ends inside octal digits
      str_buf = '{CH_BSL, "1", "2"};
      flush_string();
      wait_drained();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            // broken sequences
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 9))
                  0, 1, 2: str_buf.push_back(CH_BSL);
                  3, 4: str_buf.push_back(random_digit());
                  default: str_buf.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end else begin
            repeat ($urandom_range(1, 10)) add_token(55);
            if ($urandom_range(0, 7) == 0) begin
               str_buf.push_back(CH_BSL);
               repeat ($urandom_range(0, 2)) str_buf.push_back(random_digit());
            end
         end
         random_items += str_buf.size();
         flush_string();
      end
      wait_drained();

      $display("Checked %0d escaped bytes in, %0d decoded bytes out; input stalled %0d cycles.",
               req_count, rsp_count, stall_cycles);
      $display("Covered all escapes, octal wrap and cut-off cases, and a long receiver stall.");
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
